/* hdl/window_mean_threshold_mask_unit_macros.svh */
// assertion macros shared by the mask unit modules
// no dependencies; included by the files that carry checks
`ifndef WINDOW_MEAN_THRESHOLD_MASK_UNIT_MACROS_SVH
`define WINDOW_MEAN_THRESHOLD_MASK_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define WMT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define WMT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/wmt_pkg.sv */
// shared types and constants of the window mean threshold mask unit
// no dependencies
package wmt_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned JOB_DEPTH_DEF = 8;
  localparam int unsigned WIN           = 3;
  localparam int unsigned ROW_LIMIT     = 1024;
  localparam int unsigned ROW_W         = 10;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned CFG_DATA_W    = 11;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned COLSUM_W      = 10;
  localparam int unsigned SUM_W         = 12;
  localparam int unsigned N_RES         = WIN * WIN;
  localparam int unsigned RES_IDX_W     = 4;

  localparam logic [PIX_W-1:0]      THRESH_RST = 8'd100;
  localparam logic [PIX_W-1:0]      HIGH_RST   = 8'd255;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_THRESHOLD = 2'd0,
    CFG_HIGH_VALUE     = 2'd1,
    CFG_FRAME_WIDTH    = 2'd2,
    CFG_FRAME_HEIGHT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] grey_pixel;
    logic             frame_start;
  } wmt_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] mask_pixel;
    logic             burst_last;
    logic             frame_last;
  } wmt_out_t;

  typedef struct packed {
    logic [PIX_W-1:0]      mean_threshold;
    logic [PIX_W-1:0]      high_value;
    logic [CFG_DATA_W-1:0] frame_width;
    logic [CFG_DATA_W-1:0] frame_height;
  } wmt_cfg_t;

  // one pixel's worth of results, in emission order
  typedef struct packed {
    logic [N_RES-1:0]     dark;
    logic [RES_IDX_W-1:0] last_idx;
    logic                 frame_end;
  } wmt_job_t;

endpackage

/* hdl/wmt_job_fifo.sv */
// job queue between the classifying front end and the result sequencer
// depends on wmt_pkg and the assertion macro header
`include "window_mean_threshold_mask_unit_macros.svh"

module wmt_job_fifo import wmt_pkg::*; #(
  parameter int unsigned DEPTH = JOB_DEPTH_DEF,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wmt_job_t         job_i,
  input  logic             pop_i,
  output wmt_job_t         head_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  wmt_job_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  `WMT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && !pop_i && (count_q == CNT_W'(DEPTH)), "job queue overflow")
  `WMT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && (count_q == '0), "job queue underflow")

endmodule

/* hdl/wmt_front.sv */
// front end: raster position, two line memories, 3x3 window and
// threshold classification of every sub-window that a pixel completes
// depends on wmt_pkg
module wmt_front import wmt_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  wmt_in_t    in_i,
  input  wmt_cfg_t   cfg_i,
  output logic       job_valid_o,
  output wmt_job_t   job_o,
  output logic [1:0] inflight_o
);

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SZ_W  = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;

  // frame size, clamped
  logic [SZ_W-1:0]       w_raw, w_cl, wm1;
  logic [CFG_DATA_W-1:0] h_cl, hm1;

  always_comb begin
    w_raw = SZ_W'(cfg_i.frame_width);
    if (w_raw < SZ_W'(WIN)) begin
      w_cl = SZ_W'(WIN);
    end else if (w_raw > SZ_W'(MAX_WIDTH)) begin
      w_cl = SZ_W'(MAX_WIDTH);
    end else begin
      w_cl = w_raw;
    end
    wm1 = w_cl - 1'b1;
    if (cfg_i.frame_height < CFG_DATA_W'(WIN)) begin
      h_cl = CFG_DATA_W'(WIN);
    end else if (cfg_i.frame_height > CFG_DATA_W'(ROW_LIMIT)) begin
      h_cl = CFG_DATA_W'(ROW_LIMIT);
    end else begin
      h_cl = cfg_i.frame_height;
    end
    hm1 = h_cl - 1'b1;
  end

  // position of the incoming pixel
  logic [COL_W-1:0] col_q, col_d, c_eff;
  logic [ROW_W-1:0] row_q, row_d, r_eff;
  logic             last_col, last_row;

  always_comb begin
    c_eff    = in_i.frame_start ? '0 : col_q;
    r_eff    = in_i.frame_start ? '0 : row_q;
    last_col = (SZ_W'(c_eff) >= wm1);
    last_row = (CFG_DATA_W'(r_eff) >= hm1);
    col_d    = col_q;
    row_d    = row_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : r_eff + 1'b1;
      end else begin
        col_d = c_eff + 1'b1;
        row_d = r_eff;
      end
    end
  end

  // stage 1 control
  logic             s1_v_q, s1_bank_q, s1_rge1_q, s1_rge2_q, s1_czero_q;
  logic             s1_emit_q, s1_lcol_q, s1_lrow_q;
  logic [PIX_W-1:0] s1_pix_q;
  // stage 2 control
  logic             s2_v_q, s2_emit_q, s2_lcol_q, s2_lrow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= accept_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pix_q   <= in_i.grey_pixel;
      s1_bank_q  <= r_eff[0];
      s1_rge1_q  <= (r_eff >= ROW_W'(1));
      s1_rge2_q  <= (r_eff >= ROW_W'(2));
      s1_czero_q <= (c_eff == '0);
      s1_emit_q  <= ((r_eff >= ROW_W'(2)) || last_row) && (c_eff >= COL_W'(2));
      s1_lcol_q  <= last_col;
      s1_lrow_q  <= last_row;
    end
    if (s1_v_q) begin
      s2_emit_q <= s1_emit_q;
      s2_lcol_q <= s1_lcol_q;
      s2_lrow_q <= s1_lrow_q;
    end
  end

  // line memories, one per row parity; read before write at the same column
  logic [PIX_W-1:0] line0_mem [MAX_WIDTH];
  logic [PIX_W-1:0] line1_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd0_q <= line0_mem[c_eff];
      if (!r_eff[0]) begin
        line0_mem[c_eff] <= in_i.grey_pixel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd1_q <= line1_mem[c_eff];
      if (r_eff[0]) begin
        line1_mem[c_eff] <= in_i.grey_pixel;
      end
    end
  end

  // window: [0] two rows up, [1] one row up, [2] current row; column 2 newest
  logic [PIX_W-1:0] win_q [WIN][WIN];
  logic [PIX_W-1:0] top_px, mid_px;

  assign top_px = s1_rge2_q ? (s1_bank_q ? rd1_q : rd0_q) : '0;
  assign mid_px = s1_rge1_q ? (s1_bank_q ? rd0_q : rd1_q) : '0;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      for (int a = 0; a < WIN; a++) begin
        win_q[a][0] <= s1_czero_q ? '0 : win_q[a][1];
        win_q[a][1] <= s1_czero_q ? '0 : win_q[a][2];
      end
      win_q[0][2] <= top_px;
      win_q[1][2] <= mid_px;
      win_q[2][2] <= s1_pix_q;
    end
  end

  // sub-window sums over rows a..2 and columns b..2, compared with 9 * threshold
  logic [COLSUM_W-1:0] cs   [WIN][WIN];
  logic [SUM_W-1:0]    ssum [WIN][WIN];
  logic [SUM_W-1:0]    thr9;
  logic                dark [WIN][WIN];

  always_comb begin
    thr9 = {1'b0, cfg_i.mean_threshold, 3'b000} + SUM_W'(cfg_i.mean_threshold);
    for (int b = 0; b < WIN; b++) begin
      cs[2][b] = COLSUM_W'(win_q[2][b]);
      cs[1][b] = cs[2][b] + COLSUM_W'(win_q[1][b]);
      cs[0][b] = cs[1][b] + COLSUM_W'(win_q[0][b]);
    end
    for (int a = 0; a < WIN; a++) begin
      ssum[a][2] = SUM_W'(cs[a][2]);
      ssum[a][1] = ssum[a][2] + SUM_W'(cs[a][1]);
      ssum[a][0] = ssum[a][1] + SUM_W'(cs[a][0]);
      for (int b = 0; b < WIN; b++) begin
        dark[a][b] = (ssum[a][b] < thr9);
      end
    end
  end

  // results leave column by column, top row first
  always_comb begin
    job_o = '0;
    if (s2_lcol_q && s2_lrow_q) begin
      for (int b = 0; b < WIN; b++) begin
        for (int a = 0; a < WIN; a++) begin
          job_o.dark[b * WIN + a] = dark[a][b];
        end
      end
      job_o.last_idx = RES_IDX_W'(N_RES - 1);
    end else if (s2_lcol_q) begin
      for (int b = 0; b < WIN; b++) begin
        job_o.dark[b] = dark[0][b];
      end
      job_o.last_idx = RES_IDX_W'(WIN - 1);
    end else if (s2_lrow_q) begin
      for (int a = 0; a < WIN; a++) begin
        job_o.dark[a] = dark[a][0];
      end
      job_o.last_idx = RES_IDX_W'(WIN - 1);
    end else begin
      job_o.dark[0]  = dark[0][0];
      job_o.last_idx = '0;
    end
    job_o.frame_end = s2_lcol_q && s2_lrow_q;
  end

  assign job_valid_o = s2_v_q && s2_emit_q;
  assign inflight_o  = {1'b0, s1_v_q} + {1'b0, s2_v_q};

endmodule

/* hdl/wmt_back.sv */
// back end: walks each queued job one result per cycle, unless stalled, into the output register
// depends on wmt_pkg and the assertion macro header
`include "window_mean_threshold_mask_unit_macros.svh"

module wmt_back import wmt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PIX_W-1:0] high_value_i,
  input  wmt_job_t         head_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output wmt_out_t         out_data_o
);

  logic [RES_IDX_W-1:0] idx_q, idx_d;
  logic                 out_v_q, out_v_d;
  wmt_out_t             out_q;
  logic                 out_free, take, is_last;

  assign out_free = !out_v_q || !out_stall_i;
  assign take     = out_free && !empty_i;
  assign is_last  = (idx_q == head_i.last_idx);
  assign pop_o    = take && is_last;

  always_comb begin
    idx_d   = idx_q;
    out_v_d = out_v_q;
    if (out_free) begin
      out_v_d = !empty_i;
    end
    if (take) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.mask_pixel <= head_i.dark[idx_q] ? high_value_i : '0;
      out_q.burst_last <= is_last;
      out_q.frame_last <= is_last && head_i.frame_end;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `WMT_ASSERT(a_frame_end_closes_burst, clk_i, rst_ni, out_v_q && out_q.frame_last |-> out_q.burst_last, "frame end without burst end")
  `WMT_ASSERT(a_idx_in_job, clk_i, rst_ni, !empty_i |-> idx_q <= head_i.last_idx, "result index past end of job")

endmodule

/* hdl/window_mean_threshold_mask_unit.sv */
// top level of the 3x3 window mean threshold mask unit: config registers,
// front end, job queue and result sequencer; depends on wmt_pkg and the macro header
`include "window_mean_threshold_mask_unit_macros.svh"

// throughput: one pixel per cycle in and one result per cycle out, each unless stalled; a pixel gives 0 to 9 results
// the input stalls once the job queue credit is used up, typically during the last
// row of a frame where every completed column gives three results
// reset clears position to row 0, column 0 and sets registers to 100, 255, 640, 480;
// the line memories are not cleared and need no clearing pass
module window_mean_threshold_mask_unit import wmt_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = JOB_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  wmt_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output wmt_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  wmt_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mean_threshold <= THRESH_RST;
      cfg_q.high_value     <= HIGH_RST;
      cfg_q.frame_width    <= WIDTH_RST;
      cfg_q.frame_height   <= HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MEAN_THRESHOLD: cfg_q.mean_threshold <= cfg_data_i[PIX_W-1:0];
        CFG_HIGH_VALUE:     cfg_q.high_value     <= cfg_data_i[PIX_W-1:0];
        CFG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i;
        CFG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic             accept, job_valid, pop, empty;
  logic [1:0]       inflight;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0]   credit_used;
  wmt_job_t         job, head;

  // every pixel in the front end may still need a queue slot
  assign credit_used = {1'b0, count} + (CNT_W + 1)'(inflight);
  assign in_stall_o  = (credit_used >= (CNT_W + 1)'(QUEUE_DEPTH));
  assign accept      = in_valid_i && !in_stall_o;

  wmt_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_data_i),
    .cfg_i       (cfg_q),
    .job_valid_o (job_valid),
    .job_o       (job),
    .inflight_o  (inflight)
  );

  wmt_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .count_o (count)
  );

  wmt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .high_value_i (cfg_q.high_value),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  `WMT_ASSERT(a_credit_bound, clk_i, rst_ni, credit_used <= (CNT_W + 1)'(QUEUE_DEPTH), "queue credit exceeded")

endmodule
